// ===== design/first_match_packet_filter_defines.svh =====
// Assertion macros used by the filter RTL.
`ifndef FIRST_MATCH_PACKET_FILTER_DEFINES_SVH
`define FIRST_MATCH_PACKET_FILTER_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define FMPF_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Overlapping implication, checked out of reset.
`define FMPF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define FMPF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/fmpf_pkg.sv =====
package fmpf_pkg;

	localparam int Rules = 16;
	localparam int IdxW  = (Rules > 1) ? $clog2(Rules) : 1;
	localparam int CntW  = $clog2(Rules + 1);

	localparam logic signed [7:0] PrioMax = 8'sd10;
	localparam logic signed [7:0] PrioMin = -8'sd10;
	localparam logic [31:0] FirstId = 32'd1;

	localparam logic [7:0]  ProtoIcmp = 8'd1;
	localparam logic [7:0]  ProtoTcp  = 8'd6;
	localparam logic [7:0]  ProtoUdp  = 8'd17;
	localparam logic [15:0] IcmpFilterProhib = 16'h030D;
	localparam logic [2:0]  ActMax = 3'd3;

	typedef enum logic [1:0] {
		FUNC_CLASSIFY = 2'd0,
		FUNC_ADD      = 2'd1,
		FUNC_DELETE   = 2'd2,
		FUNC_BAD      = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		VERD_PASS   = 2'd0,
		VERD_DROP   = 2'd1,
		VERD_REJECT = 2'd2
	} verdict_t;

	typedef enum logic [1:0] {
		ACT_PRIORITY = 2'd0,
		ACT_REJECT   = 2'd1,
		ACT_DROP     = 2'd2,
		ACT_ALLOW    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [31:0] id;
		logic [3:0]  dev;
		logic [7:0]  proto;
		logic [31:0] src_addr;
		logic [31:0] src_mask;
		logic [31:0] dst_addr;
		logic [31:0] dst_mask;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [1:0]  action;
	} rule_t;

	localparam int RuleW = $bits(rule_t);

	typedef struct packed {
		logic [1:0]        func;
		logic [3:0]        dev;
		logic [7:0]        proto;
		logic [31:0]       src_addr;
		logic [31:0]       src_mask;
		logic [31:0]       dst_addr;
		logic [31:0]       dst_mask;
		logic [15:0]       src_port;
		logic [15:0]       dst_port;
		logic signed [7:0] rule_priority;
		logic [2:0]        action;
		logic [31:0]       rule_id;
	} req_t;

	typedef struct packed {
		logic            any;
		logic [IdxW-1:0] idx;
	} free_t;

	// Lowest free slot.
	function automatic free_t first_free(input logic [Rules-1:0] valid);
		free_t f;
		f = '0;
		for (int i = Rules - 1; i >= 0; i--) begin
			if (!valid[i]) begin
				f.any = 1'b1;
				f.idx = IdxW'(i);
			end
		end
		return f;
	endfunction

	// Every nonzero rule field must agree with the packet.
	function automatic logic rule_match(input rule_t r, input logic [3:0] dev,
			input logic [7:0] proto, input logic [31:0] sa, input logic [31:0] da,
			input logic [15:0] sp, input logic [15:0] dp);
		logic m;
		m = 1'b1;
		if (r.dev != '0 && r.dev != dev) m = 1'b0;
		if (r.proto != '0 && r.proto != proto) m = 1'b0;
		if (r.src_addr != '0 && (r.src_addr & r.src_mask) != (sa & r.src_mask)) m = 1'b0;
		if (r.dst_addr != '0 && (r.dst_addr & r.dst_mask) != (da & r.dst_mask)) m = 1'b0;
		if (r.src_port != '0 && r.src_port != sp) m = 1'b0;
		if (r.dst_port != '0 && r.dst_port != dp) m = 1'b0;
		return m;
	endfunction

endpackage

// ===== design/fmpf_if.sv =====
interface fmpf_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic [3:0]        dev;
	logic [7:0]        proto;
	logic [31:0]       src_addr;
	logic [31:0]       src_mask;
	logic [31:0]       dst_addr;
	logic [31:0]       dst_mask;
	logic [15:0]       src_port;
	logic [15:0]       dst_port;
	logic signed [7:0] rule_priority;
	logic [2:0]        action;
	logic [31:0]       rule_id;

	modport source (output valid, func, dev, proto, src_addr, src_mask, dst_addr, dst_mask,
		src_port, dst_port, rule_priority, action, rule_id, input ready);
	modport sink (input valid, func, dev, proto, src_addr, src_mask, dst_addr, dst_mask,
		src_port, dst_port, rule_priority, action, rule_id, output ready);
endinterface

interface fmpf_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [1:0]  verdict;
	logic        hit;
	logic [31:0] result_id;

	modport source (output valid, status, verdict, hit, result_id, input ready);
	modport sink (input valid, status, verdict, hit, result_id, output ready);
endinterface

// ===== design/fmpf_ram.sv =====
module fmpf_ram #(
	parameter int Width = 8,
	parameter int Depth = 16,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AddrW-1:0]      waddr,
	input  logic [Width-1:0]      wdata,
	input  logic                  re,
	input  logic [AddrW-1:0]      raddr,
	output logic [Width-1:0]      rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== design/first_match_packet_filter.sv =====
// First-match IPv4 packet filter.
// req channel: one transaction per operation, func selects classify, add rule
// or delete rule. rsp channel: exactly one transaction per request, carrying
// status, verdict, hit and result_id.
// Rules live in a single-port-read table RAM of RULES entries; slot valid bits
// and the next id counter are flip-flops.
// Classify and delete scan the table one slot per cycle through the RAM read
// port. Add and an ICMP filter-prohibited packet skip the scan.
// One operation is in flight at a time; the next request is taken as soon as
// the current result has moved into the response register.
// Reset empties the table (all slots invalid) and sets the next id to 1;
// no clearing pass is needed. A stalled receiver holds the response register;
// one more operation may run up to its finish state behind it and then waits.
module first_match_packet_filter
	import fmpf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	fmpf_req_if.sink  req,
	fmpf_rsp_if.source rsp
);
`include "first_match_packet_filter_defines.svh"

	state_t          state_q, state_d;
	req_t            req_q;
	logic [Rules-1:0] valid_q;
	logic [31:0]     next_id_q;
	logic [CntW-1:0] cnt_q;
	logic            vld_s1;
	logic [IdxW-1:0] idx_s1;
	logic            found_q;
	logic [31:0]     best_id_q;
	logic [1:0]      best_act_q;
	logic [IdxW-1:0] del_idx_q;
	logic [1:0]      p_status_q;
	logic [31:0]     p_id_q;

	logic            out_valid_q;
	logic [1:0]      out_status_q;
	logic [1:0]      out_verdict_q;
	logic            out_hit_q;
	logic [31:0]     out_id_q;

	rule_t           rd_rule;
	rule_t           wr_rule;
	free_t           free_slot;
	logic            is_l4;
	logic [15:0]     pkt_sp, pkt_dp;
	logic            prohib;
	logic            args_ok;
	logic            add_do;
	logic            scan_issue;
	logic            slot_hit;
	logic            finish_go;
	logic [RuleW-1:0] rd_bits;

	logic [1:0]      fin_status, fin_verdict;
	logic            fin_hit;
	logic [31:0]     fin_id;

	assign req.ready = (state_q == S_IDLE);

	assign is_l4   = (req_q.proto == ProtoTcp) || (req_q.proto == ProtoUdp);
	assign pkt_sp  = is_l4 ? req_q.src_port : '0;
	assign pkt_dp  = is_l4 ? req_q.dst_port : '0;
	assign prohib  = (req_q.proto == ProtoIcmp) && (req_q.src_port == IcmpFilterProhib);
	assign args_ok = (req_q.rule_priority <= PrioMax) && (req_q.rule_priority >= PrioMin)
		&& (req_q.action <= ActMax);
	assign free_slot = first_free(valid_q);

	assign add_do = (state_q == S_EXEC) && (func_t'(req_q.func) == FUNC_ADD)
		&& args_ok && free_slot.any;
	assign scan_issue = (state_q == S_SCAN) && (cnt_q < CntW'(Rules));
	assign finish_go  = (state_q == S_FINISH) && (!out_valid_q || rsp.ready);

	always_comb begin
		wr_rule          = '0;
		wr_rule.id       = next_id_q;
		wr_rule.dev      = req_q.dev;
		wr_rule.proto    = req_q.proto;
		wr_rule.src_addr = req_q.src_addr;
		wr_rule.src_mask = req_q.src_mask;
		wr_rule.dst_addr = req_q.dst_addr;
		wr_rule.dst_mask = req_q.dst_mask;
		wr_rule.src_port = req_q.src_port;
		wr_rule.dst_port = req_q.dst_port;
		wr_rule.action   = req_q.action[1:0];
	end

	fmpf_ram #(
		.Width (RuleW),
		.Depth (Rules)
	) u_table (
		.clk   (clk),
		.we    (add_do),
		.waddr (free_slot.idx),
		.wdata (wr_rule),
		.re    (scan_issue),
		.raddr (cnt_q[IdxW-1:0]),
		.rdata (rd_bits)
	);

	assign rd_rule  = rule_t'(rd_bits);
	assign slot_hit = vld_s1 && valid_q[idx_s1];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (func_t'(req_q.func))
					FUNC_CLASSIFY: state_d = prohib ? S_FINISH : S_SCAN;
					FUNC_DELETE:   state_d = S_SCAN;
					default:       state_d = S_FINISH;
				endcase
			end
			S_SCAN: begin
				if (vld_s1 && idx_s1 == IdxW'(Rules - 1)) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (finish_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Result of the finished operation
	always_comb begin
		fin_status  = p_status_q;
		fin_verdict = VERD_PASS;
		fin_hit     = 1'b0;
		fin_id      = p_id_q;
		case (func_t'(req_q.func))
			FUNC_CLASSIFY: begin
				fin_status = ST_OK;
				fin_hit    = found_q;
				fin_id     = found_q ? best_id_q : '0;
				if (found_q) begin
					case (action_t'(best_act_q))
						ACT_REJECT: fin_verdict = VERD_REJECT;
						ACT_DROP:   fin_verdict = VERD_DROP;
						default:    fin_verdict = VERD_PASS;
					endcase
				end
			end
			FUNC_DELETE: begin
				fin_status = found_q ? ST_OK : ST_NOT_FOUND;
				fin_id     = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			next_id_q   <= FirstId;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= scan_issue;
			if (add_do) begin
				valid_q[free_slot.idx] <= 1'b1;
				// skip zero on wrap
				next_id_q <= (next_id_q == '1) ? FirstId : next_id_q + 32'd1;
			end
			if (finish_go && func_t'(req_q.func) == FUNC_DELETE && found_q) begin
				valid_q[del_idx_q] <= 1'b0;
			end
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q.func          <= req.func;
			req_q.dev           <= req.dev;
			req_q.proto         <= req.proto;
			req_q.src_addr      <= req.src_addr;
			req_q.src_mask      <= req.src_mask;
			req_q.dst_addr      <= req.dst_addr;
			req_q.dst_mask      <= req.dst_mask;
			req_q.src_port      <= req.src_port;
			req_q.dst_port      <= req.dst_port;
			req_q.rule_priority <= req.rule_priority;
			req_q.action        <= req.action;
			req_q.rule_id       <= req.rule_id;
		end
		idx_s1 <= cnt_q[IdxW-1:0];
		if (state_q == S_EXEC) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
			// unknown func is rejected like a bad rule
			if (func_t'(req_q.func) == FUNC_BAD || !args_ok) begin
				p_status_q <= ST_INVALID;
				p_id_q     <= '0;
			end else if (!free_slot.any) begin
				p_status_q <= ST_FULL;
				p_id_q     <= '0;
			end else begin
				p_status_q <= ST_OK;
				p_id_q     <= next_id_q;
			end
		end
		if (scan_issue) begin
			cnt_q <= cnt_q + CntW'(1);
		end
		if (slot_hit) begin
			if (func_t'(req_q.func) == FUNC_DELETE) begin
				// first slot holding the id wins
				if (!found_q && rd_rule.id == req_q.rule_id) begin
					found_q   <= 1'b1;
					del_idx_q <= idx_s1;
				end
			end else if (rule_match(rd_rule, req_q.dev, req_q.proto, req_q.src_addr,
					req_q.dst_addr, pkt_sp, pkt_dp)) begin
				if (!found_q || rd_rule.id < best_id_q) begin
					found_q    <= 1'b1;
					best_id_q  <= rd_rule.id;
					best_act_q <= rd_rule.action;
				end
			end
		end
		if (finish_go) begin
			out_status_q  <= fin_status;
			out_verdict_q <= fin_verdict;
			out_hit_q     <= fin_hit;
			out_id_q      <= fin_id;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.verdict   = out_verdict_q;
	assign rsp.hit       = out_hit_q;
	assign rsp.result_id = out_id_q;

	`FMPF_ASSERT(a_next_id_nonzero, next_id_q != '0, "next id reached zero")
	`FMPF_ASSERT_IMP(a_scan_stage_in_scan, vld_s1, state_q == S_SCAN,
		"table read data outside a scan")
	`FMPF_ASSERT_NXT(a_add_fills_slot, add_do,
		$countones(valid_q) == $past($countones(valid_q)) + 1, "add did not fill a slot")
	`FMPF_ASSERT_IMP(a_hit_has_id, rsp.valid && rsp.hit,
		rsp.status == ST_OK && rsp.result_id != '0, "hit without a rule id")
	`FMPF_ASSERT_IMP(a_no_ready_while_busy, state_q != S_IDLE, !req.ready,
		"request taken while an operation is in flight")
endmodule
